// ===== rtl/ffha_pkg.sv =====
package ffha_pkg;

  // Bytes per heap word; a header occupies one word
  localparam int unsigned WordBytes = 8;
  localparam int unsigned WordShift = 3;

  // Item operation codes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FREE,
    ST_SPLIT
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept_alloc;
    logic accept_free;
    logic walk_adv;
    logic alloc_grant;
    logic alloc_miss;
    logic free_done;
    logic split_wr;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fit;
    logic walk_end;
    logic split_rest;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/ffha_ctrl.sv =====
module ffha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             opcode_i,
  output logic             in_stall_o,
  input  ffha_pkg::status_t sts_i,
  output ffha_pkg::cmd_t    cmd_o
);

  ffha_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffha_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == ffha_pkg::OP_FREE) begin
            state_d = ffha_pkg::ST_FREE;
          end else begin
            state_d = ffha_pkg::ST_WALK;
          end
        end
      end
      ffha_pkg::ST_WALK: begin
        if (sts_i.out_free) begin
          if (sts_i.fit) begin
            state_d = sts_i.split_rest ? ffha_pkg::ST_SPLIT : ffha_pkg::ST_IDLE;
          end else if (sts_i.walk_end) begin
            state_d = ffha_pkg::ST_IDLE;
          end
        end
      end
      ffha_pkg::ST_FREE: begin
        if (sts_i.out_free) begin
          state_d = ffha_pkg::ST_IDLE;
        end
      end
      ffha_pkg::ST_SPLIT: begin
        state_d = ffha_pkg::ST_IDLE;
      end
      default: begin
        state_d = ffha_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands and input stall; the walk advances even while a result waits
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ffha_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (opcode_i == ffha_pkg::OP_FREE) begin
            cmd_o.accept_free = 1'b1;
          end else begin
            cmd_o.accept_alloc = 1'b1;
          end
        end
      end
      ffha_pkg::ST_WALK: begin
        if (sts_i.fit) begin
          cmd_o.alloc_grant = sts_i.out_free;
        end else if (sts_i.walk_end) begin
          cmd_o.alloc_miss = sts_i.out_free;
        end else begin
          cmd_o.walk_adv = 1'b1;
        end
      end
      ffha_pkg::ST_FREE: begin
        cmd_o.free_done = sts_i.out_free;
      end
      ffha_pkg::ST_SPLIT: begin
        cmd_o.split_wr = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // The remainder header is only written straight after a split grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.split_wr |-> $past(cmd_o.alloc_grant))
    else $error("split write without a preceding grant");

  // A result is only produced when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.alloc_grant || cmd_o.alloc_miss || cmd_o.free_done) |-> sts_i.out_free)
    else $error("result produced into a full output register");

  // At most one command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one command issued");

endmodule

// ===== rtl/ffha_datapath.sv =====
module ffha_datapath #(
  parameter int unsigned HEAP_BYTES = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [9:0]        request_bytes_i,
  input  logic [5:0]        payload_index_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              granted_o,
  output logic [5:0]        granted_index_o,
  output logic              was_allocated_o,
  input  ffha_pkg::cmd_t    cmd_i,
  output ffha_pkg::status_t sts_o
);

  localparam int unsigned Words  = HEAP_BYTES / ffha_pkg::WordBytes;
  localparam int unsigned IdxW   = $clog2(Words);
  localparam int unsigned HdrW   = $clog2(HEAP_BYTES + 1);
  localparam int unsigned CalcW  = ((HdrW > 11) ? HdrW : 11) + 1;
  localparam logic [CalcW-1:0] WordsC = CalcW'(Words);

  // Header store
  logic [HdrW-1:0] mem_q [Words];
  logic [HdrW-1:0] mem_rd_q;
  logic [IdxW-1:0] rd_addr_q;
  logic            hdr0_set_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [HdrW-1:0] wr_data;

  // Walk and free registers
  logic [CalcW-1:0] need_q, rounded_q;
  logic [IdxW:0]    w_q;
  logic [IdxW-1:0]  fidx_q;
  logic             fidx_ok_q;
  logic [IdxW-1:0]  split_addr_q;
  logic [HdrW-1:0]  split_val_q;

  // Result register
  logic       out_valid_q;
  logic       granted_q;
  logic [5:0] granted_index_q;
  logic       was_allocated_q;

  logic [HdrW-1:0]  hdr;
  logic [CalcW-1:0] need, rounded, sz, step, w_ext, w_next, rest, fidx_m1, grant_idx;
  logic             split, res_load;

  // Request size with header, rounded to whole words
  assign need    = CalcW'(request_bytes_i) + CalcW'(ffha_pkg::WordBytes);
  assign rounded = (need + CalcW'(7)) & ~CalcW'(7);

  // Header just read; entry 0 reads as one free heap block until written
  assign hdr   = (rd_addr_q == '0 && !hdr0_set_q) ? HdrW'(HEAP_BYTES) : mem_rd_q;
  assign sz    = CalcW'(hdr) & ~CalcW'(1);
  assign step  = sz >> ffha_pkg::WordShift;
  assign w_ext = CalcW'(w_q);
  assign w_next    = w_ext + step;
  assign split     = sz > (rounded_q + CalcW'(ffha_pkg::WordBytes));
  assign rest      = w_ext + (rounded_q >> ffha_pkg::WordShift);
  assign grant_idx = w_ext + CalcW'(1);
  assign fidx_m1   = CalcW'(payload_index_i) - CalcW'(1);

  assign sts_o.fit        = !hdr[0] && (need_q <= sz);
  assign sts_o.walk_end   = (step == '0) || (w_next >= WordsC);
  assign sts_o.split_rest = split && (rest < WordsC);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // Read port address
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd_i.accept_alloc) begin
      rd_en = 1'b1;
    end else if (cmd_i.walk_adv) begin
      rd_en   = 1'b1;
      rd_addr = w_next[IdxW-1:0];
    end else if (cmd_i.accept_free) begin
      rd_en   = 1'b1;
      rd_addr = fidx_m1[IdxW-1:0];
    end
  end

  // Write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = w_q[IdxW-1:0];
    wr_data = hdr | HdrW'(1);
    if (cmd_i.alloc_grant) begin
      wr_en = 1'b1;
      if (split) begin
        wr_data = rounded_q[HdrW-1:0] | HdrW'(1);
      end
    end else if (cmd_i.split_wr) begin
      wr_en   = 1'b1;
      wr_addr = split_addr_q;
      wr_data = split_val_q;
    end else if (cmd_i.free_done && fidx_ok_q && hdr[0]) begin
      wr_en   = 1'b1;
      wr_addr = fidx_q;
      wr_data = hdr & ~HdrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_set_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (wr_en && wr_addr == '0) begin
        hdr0_set_q <= 1'b1;
      end
      if (rd_en) begin
        rd_addr_q <= rd_addr;
      end
    end
  end

  // Walk position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else if (cmd_i.accept_alloc) begin
      w_q <= '0;
    end else if (cmd_i.walk_adv) begin
      w_q <= w_next[IdxW:0];
    end
  end

  // Capture item operands and the remainder header
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_alloc) begin
      need_q    <= need;
      rounded_q <= rounded;
    end
    if (cmd_i.accept_free) begin
      fidx_q    <= fidx_m1[IdxW-1:0];
      fidx_ok_q <= (payload_index_i != '0) && (fidx_m1 < WordsC);
    end
    if (cmd_i.alloc_grant) begin
      split_addr_q <= rest[IdxW-1:0];
      split_val_q  <= HdrW'(sz - rounded_q);
    end
  end

  // Result word
  assign res_load = cmd_i.alloc_grant || cmd_i.alloc_miss || cmd_i.free_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      granted_q       <= cmd_i.alloc_grant;
      granted_index_q <= cmd_i.alloc_grant ? grant_idx[5:0] : 6'd0;
      was_allocated_q <= cmd_i.free_done && fidx_ok_q && hdr[0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign granted_index_o = granted_index_q;
  assign was_allocated_o = was_allocated_q;

  // The walk never rests beyond the heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CalcW'(w_q) < WordsC)
    else $error("walk position beyond heap");

  // A result appears only after a result load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(res_load))
    else $error("result word appeared without a load");

  // The result word stays put while the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(granted_index_q)
      && $stable(granted_q) && $stable(was_allocated_q)))
    else $error("stalled result word changed");

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator over an implicit list of one-word block headers in a heap of
// HEAP_BYTES bytes (8-byte words). An allocate word walks the headers from word 0 at one
// header per cycle through a single registered-read header store and takes the first
// free block that fits; when the block is split, a further split state writes the
// remainder header. A free word reads one header and then clears its allocated mark
// if it was set. The final grant, miss or free result of a word waits as long as the
// previous result is still held in the output register. The block works on one word
// at a time; a finished result sits in an output register, so a new word is taken
// while the previous result waits.
// Freed blocks are not coalesced and freed indices are not checked against the list.
module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       opcode_i,
  input  logic [9:0] request_bytes_i,
  input  logic [5:0] payload_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       granted_o,
  output logic [5:0] granted_index_o,
  output logic       was_allocated_o
);

  ffha_pkg::cmd_t    cmd;
  ffha_pkg::status_t sts;

  // Sequencing
  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Header store, walk arithmetic and result register
  ffha_datapath #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .request_bytes_i (request_bytes_i),
    .payload_index_i (payload_index_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .granted_o       (granted_o),
    .granted_index_o (granted_index_o),
    .was_allocated_o (was_allocated_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// ===== tb/heap_grant_checker.sv =====
module heap_grant_checker #(
  parameter int unsigned HEAP_BYTES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       opcode_i,
  input  logic [9:0] request_bytes_i,
  input  logic [5:0] payload_index_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       granted_i,
  input  logic [5:0] granted_index_i,
  input  logic       was_allocated_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  localparam int unsigned HeapWords  = HEAP_BYTES / ffha_pkg::WordBytes;
  localparam int          HdrW       = $clog2(HEAP_BYTES + 1);
  localparam int          MaxReports = 10;

  typedef struct packed {
    logic       granted;
    logic [5:0] index;
    logic       freed;
  } heap_result_t;

  // Shadow of the block header words
  logic [HdrW-1:0] hdr_store [HeapWords];
  heap_result_t    grants_due [$];
  int              misses;

  // Walk the headers from word 0 and take the first free block that fits
  task automatic walk_first_fit(input logic [9:0] req, output heap_result_t res);
    int unsigned     word, need, rounded, size, stride, rest;
    logic [HdrW-1:0] hdr;
    logic            done;
    res     = '0;
    word    = 0;
    need    = req + ffha_pkg::WordBytes;
    rounded = (need + 7) & ~32'd7;
    done    = 1'b0;
    while (!done && word < HeapWords) begin
      hdr    = hdr_store[word];
      size   = {hdr[HdrW-1:1], 1'b0};
      stride = size / ffha_pkg::WordBytes;
      if (!hdr[0] && need <= size) begin
        // Split only when more than one word would be left over
        if (size > rounded + ffha_pkg::WordBytes) begin
          rest            = word + rounded / ffha_pkg::WordBytes;
          hdr_store[word] = HdrW'(rounded | 32'd1);
          if (rest < HeapWords) hdr_store[rest] = HdrW'(size - rounded);
        end else begin
          hdr_store[word] = hdr | HdrW'(1);
        end
        res.granted = 1'b1;
        res.index   = 6'(word + 1);
        done        = 1'b1;
      end else if (stride == 0) begin
        done = 1'b1;
      end else begin
        word += stride;
      end
    end
  endtask

  // Clear the mark of the header one word before the payload
  task automatic clear_alloc_mark(input logic [5:0] idx, output heap_result_t res);
    res = '0;
    if (idx != 0 && idx - 1 < HeapWords) begin
      if (hdr_store[idx-1][0]) begin
        hdr_store[idx-1][0] = 1'b0;
        res.freed           = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t seen, due;
    if (!rst_ni) begin
      for (int w = 0; w < HeapWords; w++) hdr_store[w] = '0;
      hdr_store[0] = HdrW'(HEAP_BYTES);
      grants_due.delete();
      misses = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      // Compare a delivered word against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        seen.granted = granted_i;
        seen.index   = granted_index_i;
        seen.freed   = was_allocated_i;
        if (grants_due.size() == 0) begin
          misses++;
          if (misses <= MaxReports)
            $display("%0t: unexpected result granted=%0b index=%0d freed=%0b",
                     $time, seen.granted, seen.index, seen.freed);
        end else begin
          due = grants_due.pop_front();
          if (seen.granted !== due.granted || seen.index !== due.index ||
              seen.freed !== due.freed) begin
            misses++;
            if (misses <= MaxReports)
              $display("%0t: mismatch expected granted=%0b index=%0d freed=%0b, %s%0b %s%0d %s%0b",
                       $time, due.granted, due.index, due.freed,
                       "got granted=", seen.granted, "index=", seen.index,
                       "freed=", seen.freed);
          end
        end
      end
      // Predict the outcome of an accepted word
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == ffha_pkg::OP_FREE) clear_alloc_mark(payload_index_i, due);
        else walk_first_fit(request_bytes_i, due);
        grants_due.push_back(due);
      end
      mismatch_count_o <= misses;
      pending_o        <= grants_due.size();
    end
  end

endmodule

// ===== tb/tb_first_fit_heap_allocator_top.sv =====
module tb_first_fit_heap_allocator_top;

  localparam int unsigned HEAP_BYTES  = 512;
  localparam int unsigned HeapWords   = HEAP_BYTES / ffha_pkg::WordBytes;
  localparam int          RandomWords = 1350;
  localparam int          HoldCycles  = 250;
  localparam int          QuietLimit  = 1000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       opcode_i;
  logic [9:0] request_bytes_i;
  logic [5:0] payload_index_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       granted_o;
  logic [5:0] granted_index_o;
  logic       was_allocated_o;

  int          fail_count;
  int          pending;
  int          words_sent  = 0;
  int          quiet_cycles = 0;
  // Payload indices whose header word is known to exist
  logic [63:0] freeable = 64'h2;

  always #10 clk_i = ~clk_i;

  first_fit_heap_allocator_top #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .request_bytes_i(request_bytes_i),
    .payload_index_i(payload_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .granted_o      (granted_o),
    .granted_index_o(granted_index_o),
    .was_allocated_o(was_allocated_o)
  );

  heap_grant_checker #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .opcode_i        (opcode_i),
    .request_bytes_i (request_bytes_i),
    .payload_index_i (payload_index_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .granted_i       (granted_o),
    .granted_index_i (granted_index_o),
    .was_allocated_i (was_allocated_o),
    .mismatch_count_o(fail_count),
    .pending_o       (pending)
  );

  // Offer one word and hold it until accepted
  task automatic offer_word(input ffha_pkg::opcode_e op, input logic [9:0] req,
                            input logic [5:0] idx);
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    request_bytes_i <= req;
    payload_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Record granted payloads so that frees only name written headers
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i && granted_o && granted_index_o != 0)
      freeable[granted_index_o] <= 1'b1;
  end

  // Count cycles in which neither channel moves a word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: stall in phases of differing density, with one long hold-off
  initial begin
    int   mode, span;
    logic held;
    out_stall_i = 1'b0;
    held        = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && words_sent >= 300) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int k = 0; k < span; k++) begin
        case (mode)
          0: begin
            out_stall_i <= 1'b0;
          end
          1: begin
            out_stall_i <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall_i <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            out_stall_i <= (k % 4 == 3);
          end
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Sender: directed words, then random bursts
  initial begin
    int                items_left, burst, gap, start;
    logic [9:0]        req;
    logic [5:0]        idx;
    ffha_pkg::opcode_e op;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    opcode_i        = ffha_pkg::OP_ALLOC;
    request_bytes_i = '0;
    payload_index_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Miss by walking off the heap, then split and round small requests
    offer_word(ffha_pkg::OP_ALLOC, 10'd512, 6'd0);
    offer_word(ffha_pkg::OP_ALLOC, 10'd0,   6'd63);
    offer_word(ffha_pkg::OP_ALLOC, 10'd1,   6'd0);
    offer_word(ffha_pkg::OP_ALLOC, 10'd7,   6'd0);
    // Free outside the heap, then a free and a double free
    offer_word(ffha_pkg::OP_FREE,  10'd1023, 6'd0);
    offer_word(ffha_pkg::OP_FREE,  10'd0,   6'd1);
    offer_word(ffha_pkg::OP_FREE,  10'd0,   6'd1);
    // Reuse a one-word block whole, then miss and take an exact fit
    offer_word(ffha_pkg::OP_ALLOC, 10'd0,   6'd0);
    offer_word(ffha_pkg::OP_ALLOC, 10'd465, 6'd0);
    offer_word(ffha_pkg::OP_ALLOC, 10'd464, 6'd0);
    offer_word(ffha_pkg::OP_ALLOC, 10'd0,   6'd0);
    offer_word(ffha_pkg::OP_FREE,  10'd0,   6'd2);
    offer_word(ffha_pkg::OP_FREE,  10'd0,   6'd4);
    offer_word(ffha_pkg::OP_FREE,  10'd0,   6'd6);
    offer_word(ffha_pkg::OP_ALLOC, 10'd8,   6'd0);
    offer_word(ffha_pkg::OP_ALLOC, 10'd100, 6'd0);
    offer_word(ffha_pkg::OP_ALLOC, 10'd511, 6'd0);
    offer_word(ffha_pkg::OP_ALLOC, 10'd9,   6'd0);
    in_valid_i <= 1'b0;
    repeat (3) @(posedge clk_i);

    // Random bursts of mostly small allocations mixed with frees
    items_left = RandomWords;
    while (items_left > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && items_left > 0) begin
        if ($urandom_range(0, 99) < 38) begin
          op  = ffha_pkg::OP_FREE;
          req = 10'($urandom_range(0, 1023));
          if ($urandom_range(0, 19) == 0) begin
            idx = 6'd0;
          end else begin
            start = $urandom_range(1, 63);
            idx   = 6'(start);
            while (!freeable[idx]) idx = (idx == 6'd63) ? 6'd1 : idx + 6'd1;
          end
        end else begin
          op  = ffha_pkg::OP_ALLOC;
          idx = 6'($urandom_range(0, 63));
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: req = 10'($urandom_range(0, 24));
            12, 13, 14, 15, 16: req = 10'($urandom_range(0, 120));
            17, 18: req = 10'($urandom_range(0, 512));
            default: req = 10'($urandom_range(504, 512));
          endcase
        end
        offer_word(op, req, idx);
        burst--;
        items_left--;
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(40, 80);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow for the longest walk
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (HeapWords + 16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
